// ----- sv/bhs_pkg.sv -----
// Shared types and constants for the bilinear heightmap sampler.
// No dependencies; every other file imports this package.
`default_nettype none

package bhs_pkg;

  localparam int POS_W     = 24;
  localparam int REL_W     = POS_W + 1;
  localparam int CPU_W     = 24;
  localparam int CPU_FRAC  = 16;
  localparam int PROD_W    = REL_W + CPU_W;
  localparam int IDX_W     = PROD_W - CPU_FRAC;
  localparam int FRAC_W    = 8;
  localparam int WT_W      = FRAC_W + 1;
  localparam int GAIN_W    = 18;
  localparam int GAIN_FRAC = 16;
  localparam int OUT_W     = 34;
  localparam int CELL_W    = 8;
  localparam int HIN_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int PIPE_DEPTH = 8;

  localparam logic [WT_W-1:0] WT_ONE = WT_W'(1 << FRAC_W);

  localparam logic signed [POS_W-1:0] ORIGIN_RST = -24'sd32768;
  localparam logic [CPU_W-1:0]        CPU_RST    = 24'd65536;
  localparam logic [GAIN_W-1:0]       GAIN_RST   = 18'd328;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X       = 2'd0,
    CFG_ORIGIN_Z       = 2'd1,
    CFG_CELLS_PER_UNIT = 2'd2,
    CFG_HEIGHT_GAIN    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // per-word control that travels down the pipeline
  typedef struct packed {
    logic sample;
    logic wr_ok;
    logic clamped;
  } ctl_t;

endpackage

`default_nettype wire

// ----- sv/bhs_ifs.sv -----
// Valid/ready channel interfaces for request and result words.
// Depends on bhs_pkg.
`default_nettype none

interface bhs_in_if
  import bhs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_z;
  logic [CELL_W-1:0]        cell_x;
  logic [CELL_W-1:0]        cell_z;
  logic signed [HIN_W-1:0]  cell_height;

  modport source (output valid, op, pos_x, pos_z, cell_x, cell_z, cell_height,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_z, cell_x, cell_z, cell_height,
                  output ready);
endinterface

interface bhs_out_if
  import bhs_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [OUT_W-1:0]  height_out;
  logic                     out_of_range;

  modport source (output valid, height_out, out_of_range, input ready);
  modport sink   (input valid, height_out, out_of_range, output ready);
endinterface

`default_nettype wire

// ----- sv/bhs_map.sv -----
// Position to grid index: offset, scale, floor, clamp (three stages).
// Depends on bhs_pkg.
`default_nettype none

module bhs_map
  import bhs_pkg::*;
#(
  parameter int GRID_DIM    = 256,
  parameter int HEIGHT_BITS = 16,
  localparam int CW         = $clog2(GRID_DIM)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic signed [POS_W-1:0]       pos_x,
  input  logic signed [POS_W-1:0]       pos_z,
  input  logic [CELL_W-1:0]             cell_x,
  input  logic [CELL_W-1:0]             cell_z,
  input  logic signed [HIN_W-1:0]       cell_height,
  input  logic signed [POS_W-1:0]       origin_x,
  input  logic signed [POS_W-1:0]       origin_z,
  input  logic [CPU_W-1:0]              cells_per_unit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctl_t                          ctl,
  output logic [CW-1:0]                 lx,
  output logic [CW-1:0]                 lz,
  output logic [WT_W-1:0]               fx,
  output logic [WT_W-1:0]               fz,
  output logic [CW-1:0]                 wr_x,
  output logic [CW-1:0]                 wr_z,
  output logic signed [HEIGHT_BITS-1:0] wr_h
);

  localparam int XW = ((CW > CELL_W) ? CW : CELL_W) + 1;
  localparam int IW = CW + FRAC_W;
  localparam logic signed [IDX_W-1:0] TOP_IDX = IDX_W'((GRID_DIM - 1) * (1 << FRAC_W));
  localparam logic [IW-1:0]           TOP_IX  = IW'((GRID_DIM - 1) * (1 << FRAC_W));
  localparam logic [CW-1:0]           LO_MAX  = CW'(GRID_DIM - 2);

  typedef struct packed {
    logic              clamp;
    logic [CW-1:0]     lo;
    logic [WT_W-1:0]   frac;
  } axis_t;

  function automatic axis_t axis_map(input logic signed [PROD_W-1:0] p);
    logic signed [IDX_W-1:0] idx;
    logic [IW-1:0]           ix;
    axis_t                   a;
    idx     = p[PROD_W-1:CPU_FRAC];
    a.clamp = 1'b0;
    if (idx[IDX_W-1]) begin
      ix      = '0;
      a.clamp = 1'b1;
    end else if (idx > TOP_IDX) begin
      ix      = TOP_IX;
      a.clamp = 1'b1;
    end else begin
      ix = idx[IW-1:0];
    end
    // top edge: keep the last pair of cells, full weight on the upper one
    if (ix[IW-1:FRAC_W] > LO_MAX) begin
      a.lo   = LO_MAX;
      a.frac = WT_ONE;
    end else begin
      a.lo   = ix[IW-1:FRAC_W];
      a.frac = {1'b0, ix[FRAC_W-1:0]};
    end
    return a;
  endfunction

  logic v1, v2, v3;
  logic en1, en2, en3;

  ctl_t                          ctl1, ctl2, ctl3;
  logic signed [REL_W-1:0]       rel_x1, rel_z1;
  logic signed [PROD_W-1:0]      prod_x2, prod_z2;
  logic [CW-1:0]                 wx1, wz1, wx2, wz2, wx3, wz3;
  logic signed [HEIGHT_BITS-1:0] wh1, wh2, wh3;
  logic [CW-1:0]                 lx3, lz3;
  logic [WT_W-1:0]               fx3, fz3;

  ctl_t                          ctl1_next, ctl3_next;
  logic signed [REL_W-1:0]       rel_x_next, rel_z_next;
  logic signed [PROD_W-1:0]      prod_x_next, prod_z_next;
  logic signed [CPU_W:0]         cpu_s;
  axis_t                         ax, az;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign ctl1_next.sample  = (op == OP_SAMPLE);
  assign ctl1_next.wr_ok   = (XW'(cell_x) < XW'(GRID_DIM)) && (XW'(cell_z) < XW'(GRID_DIM));
  assign ctl1_next.clamped = 1'b0;
  assign rel_x_next = REL_W'(pos_x) - REL_W'(origin_x);
  assign rel_z_next = REL_W'(pos_z) - REL_W'(origin_z);

  assign cpu_s       = $signed({1'b0, cells_per_unit});
  assign prod_x_next = rel_x1 * cpu_s;
  assign prod_z_next = rel_z1 * cpu_s;

  assign ax = axis_map(prod_x2);
  assign az = axis_map(prod_z2);
  assign ctl3_next.sample  = ctl2.sample;
  assign ctl3_next.wr_ok   = ctl2.wr_ok;
  assign ctl3_next.clamped = ctl2.sample && (ax.clamp || az.clamp);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1   <= ctl1_next;
      rel_x1 <= rel_x_next;
      rel_z1 <= rel_z_next;
      wx1    <= CW'(cell_x);
      wz1    <= CW'(cell_z);
      wh1    <= HEIGHT_BITS'(cell_height);
    end
    if (en2) begin
      ctl2    <= ctl1;
      prod_x2 <= prod_x_next;
      prod_z2 <= prod_z_next;
      wx2     <= wx1;
      wz2     <= wz1;
      wh2     <= wh1;
    end
    if (en3) begin
      ctl3 <= ctl3_next;
      lx3  <= ax.lo;
      lz3  <= az.lo;
      fx3  <= ax.frac;
      fz3  <= az.frac;
      wx3  <= wx2;
      wz3  <= wz2;
      wh3  <= wh2;
    end
  end

  assign out_valid = v3;
  assign ctl       = ctl3;
  assign lx        = lx3;
  assign lz        = lz3;
  assign fx        = fx3;
  assign fz        = fz3;
  assign wr_x      = wx3;
  assign wr_z      = wz3;
  assign wr_h      = wh3;

endmodule

`default_nettype wire

// ----- sv/bhs_grid.sv -----
// Height grid in four banks split by column and row parity, so the four
// neighbours of a sample are read out in the same cycle. Depends on bhs_pkg.
`default_nettype none

module bhs_grid
  import bhs_pkg::*;
#(
  parameter int GRID_DIM    = 256,
  parameter int HEIGHT_BITS = 16,
  localparam int CW         = $clog2(GRID_DIM)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ctl_t                          ctl_in,
  input  logic [CW-1:0]                 lx,
  input  logic [CW-1:0]                 lz,
  input  logic [WT_W-1:0]               fx_in,
  input  logic [WT_W-1:0]               fz_in,
  input  logic [CW-1:0]                 wr_x,
  input  logic [CW-1:0]                 wr_z,
  input  logic signed [HEIGHT_BITS-1:0] wr_h,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctl_t                          ctl,
  output logic [WT_W-1:0]               fx,
  output logic [WT_W-1:0]               fz,
  output logic signed [HEIGHT_BITS-1:0] c00,
  output logic signed [HEIGHT_BITS-1:0] c10,
  output logic signed [HEIGHT_BITS-1:0] c01,
  output logic signed [HEIGHT_BITS-1:0] c11
);

  localparam int HW         = CW - 1;
  localparam int AW         = 2 * HW;
  localparam int BANK_DEPTH = 1 << AW;

  // bank name: column parity then row parity
  logic signed [HEIGHT_BITS-1:0] mem00 [BANK_DEPTH];
  logic signed [HEIGHT_BITS-1:0] mem10 [BANK_DEPTH];
  logic signed [HEIGHT_BITS-1:0] mem01 [BANK_DEPTH];
  logic signed [HEIGHT_BITS-1:0] mem11 [BANK_DEPTH];
  logic signed [HEIGHT_BITS-1:0] rd00, rd10, rd01, rd11;

  logic            v4, en4, wr_go;
  ctl_t            ctl4;
  logic [WT_W-1:0] fx4, fz4;
  logic            lx0, lz0;
  logic [CW-1:0]   lx_inc, lz_inc, xe, xo, ze, zo;
  logic [AW-1:0]   waddr, ra00, ra10, ra01, ra11;
  logic signed [HEIGHT_BITS-1:0] even_r0, odd_r0, even_r1, odd_r1;

  assign en4      = !v4 || out_ready;
  assign in_ready = en4;
  assign wr_go    = en4 && in_valid && !ctl_in.sample && ctl_in.wr_ok;

  assign lx_inc = lx + CW'(1);
  assign lz_inc = lz + CW'(1);
  assign xe     = lx[0] ? lx_inc : lx;
  assign xo     = lx[0] ? lx : lx_inc;
  assign ze     = lz[0] ? lz_inc : lz;
  assign zo     = lz[0] ? lz : lz_inc;
  assign ra00   = {ze[CW-1:1], xe[CW-1:1]};
  assign ra10   = {ze[CW-1:1], xo[CW-1:1]};
  assign ra01   = {zo[CW-1:1], xe[CW-1:1]};
  assign ra11   = {zo[CW-1:1], xo[CW-1:1]};
  assign waddr  = {wr_z[CW-1:1], wr_x[CW-1:1]};

  always_ff @(posedge clk) begin
    if (wr_go && !wr_x[0] && !wr_z[0]) mem00[waddr] <= wr_h;
    if (wr_go &&  wr_x[0] && !wr_z[0]) mem10[waddr] <= wr_h;
    if (wr_go && !wr_x[0] &&  wr_z[0]) mem01[waddr] <= wr_h;
    if (wr_go &&  wr_x[0] &&  wr_z[0]) mem11[waddr] <= wr_h;
    if (en4) begin
      rd00 <= mem00[ra00];
      rd10 <= mem10[ra10];
      rd01 <= mem01[ra01];
      rd11 <= mem11[ra11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      ctl4 <= ctl_in;
      fx4  <= fx_in;
      fz4  <= fz_in;
      lx0  <= lx[0];
      lz0  <= lz[0];
    end
  end

  // undo the parity split
  assign even_r0 = lz0 ? rd01 : rd00;
  assign odd_r0  = lz0 ? rd11 : rd10;
  assign even_r1 = lz0 ? rd00 : rd01;
  assign odd_r1  = lz0 ? rd10 : rd11;
  assign c00     = lx0 ? odd_r0  : even_r0;
  assign c10     = lx0 ? even_r0 : odd_r0;
  assign c01     = lx0 ? odd_r1  : even_r1;
  assign c11     = lx0 ? even_r1 : odd_r1;

  assign out_valid = v4;
  assign ctl       = ctl4;
  assign fx        = fx4;
  assign fz        = fz4;

endmodule

`default_nettype wire

// ----- sv/bhs_blend.sv -----
// Bilinear blend: x weighting per row, then z weighting (two stages).
// Depends on bhs_pkg.
`default_nettype none

module bhs_blend
  import bhs_pkg::*;
#(
  parameter int HEIGHT_BITS = 16,
  localparam int BW         = HEIGHT_BITS + 2 * FRAC_W + 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ctl_t                          ctl_in,
  input  logic [WT_W-1:0]               fx,
  input  logic [WT_W-1:0]               fz,
  input  logic signed [HEIGHT_BITS-1:0] c00,
  input  logic signed [HEIGHT_BITS-1:0] c10,
  input  logic signed [HEIGHT_BITS-1:0] c01,
  input  logic signed [HEIGHT_BITS-1:0] c11,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ctl_t                          ctl,
  output logic signed [BW-1:0]          blend
);

  localparam int RW = HEIGHT_BITS + FRAC_W + 1;

  logic v5, v6, en5, en6;
  ctl_t ctl5, ctl6;
  logic [WT_W-1:0]      wx0, wz0_5, wz1_5;
  logic signed [RW-1:0] rz0_next, rz1_next, rz0_5, rz1_5;
  logic signed [BW-1:0] blend_next, blend6;

  assign en6      = !v6 || out_ready;
  assign en5      = !v5 || en6;
  assign in_ready = en5;

  assign wx0      = WT_ONE - fx;
  assign rz0_next = c00 * $signed({1'b0, wx0}) + c10 * $signed({1'b0, fx});
  assign rz1_next = c01 * $signed({1'b0, wx0}) + c11 * $signed({1'b0, fx});

  assign blend_next = rz0_5 * $signed({1'b0, wz0_5}) + rz1_5 * $signed({1'b0, wz1_5});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en5) v5 <= in_valid;
      if (en6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      ctl5  <= ctl_in;
      rz0_5 <= rz0_next;
      rz1_5 <= rz1_next;
      wz0_5 <= WT_ONE - fz;
      wz1_5 <= fz;
    end
    if (en6) begin
      ctl6   <= ctl5;
      blend6 <= blend_next;
    end
  end

  assign out_valid = v6;
  assign ctl       = ctl6;
  assign blend     = blend6;

endmodule

`default_nettype wire

// ----- sv/bhs_scale.sv -----
// Gain scaling with floor and saturation, plus the output register; write words give zero.
// Depends on bhs_pkg.
`default_nettype none

module bhs_scale
  import bhs_pkg::*;
#(
  parameter int HEIGHT_BITS = 16,
  localparam int BW         = HEIGHT_BITS + 2 * FRAC_W + 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ctl_t                    ctl_in,
  input  logic signed [BW-1:0]    blend,
  input  logic [GAIN_W-1:0]       gain,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] height_out,
  output logic                    out_of_range
);

  localparam int LO_W  = BW / 2;
  localparam int HI_W  = BW - LO_W;
  localparam int PL_W  = LO_W + GAIN_FRAC;
  localparam int PH_W  = HI_W + GAIN_FRAC + 1;
  localparam int PG_W  = BW + 2;
  localparam int FW    = BW + GAIN_FRAC + 1;
  localparam int RSW   = BW + 3;
  localparam int SW    = (RSW > OUT_W) ? RSW : OUT_W;
  localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [SW-1:0] SAT_LO = SW'($signed({1'b1, {(OUT_W-1){1'b0}}}));

  logic v7, v8, en7, en8;
  ctl_t ctl7;
  logic [GAIN_W-GAIN_FRAC-1:0] gh;
  logic [GAIN_FRAC-1:0]        gl;
  logic [PL_W-1:0]             plo_next, plo7;
  logic signed [PH_W-1:0]      phi_next, phi7;
  logic signed [PG_W-1:0]      pg_next, pg7;
  logic signed [FW-1:0]        hi_ext, lo_ext, full;
  logic signed [BW:0]          fl;
  logic signed [RSW-1:0]       res;
  logic signed [SW-1:0]        res_w;
  logic signed [OUT_W-1:0]     h_next, h8;
  logic                        oor8;

  assign en8      = !v8 || out_ready;
  assign en7      = !v7 || en8;
  assign in_ready = en7;

  // blend * gain split into narrow partial products
  assign gh       = gain[GAIN_W-1:GAIN_FRAC];
  assign gl       = gain[GAIN_FRAC-1:0];
  assign plo_next = blend[LO_W-1:0] * gl;
  assign phi_next = $signed(blend[BW-1:LO_W]) * $signed({1'b0, gl});
  assign pg_next  = blend * $signed({1'b0, gh});

  assign hi_ext = FW'(phi7) <<< LO_W;
  assign lo_ext = FW'(plo7);
  assign full   = hi_ext + lo_ext;
  assign fl     = full[FW-1:GAIN_FRAC];
  assign res    = RSW'(fl) + RSW'(pg7);
  assign res_w  = SW'(res);

  always_comb begin
    priority if (!ctl7.sample) h_next = '0;
    else if (res_w > SAT_HI)   h_next = OUT_W'(SAT_HI);
    else if (res_w < SAT_LO)   h_next = OUT_W'(SAT_LO);
    else                       h_next = OUT_W'(res_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (en7) v7 <= in_valid;
      if (en8) v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      ctl7 <= ctl_in;
      plo7 <= plo_next;
      phi7 <= phi_next;
      pg7  <= pg_next;
    end
    if (en8) begin
      h8   <= h_next;
      oor8 <= ctl7.clamped;
    end
  end

  assign out_valid    = v8;
  assign height_out   = h8;
  assign out_of_range = oor8;

endmodule

`default_nettype wire

// ----- sv/bilinear_heightmap_sampler.sv -----
// Bilinear heightmap sampler, top level. Depends on bhs_pkg, bhs_ifs, bhs_map,
// bhs_grid, bhs_blend and bhs_scale.
// Words pass the map, grid, blend and scale stages in order. Throughput: one
// word per clock unless dout stalls; the grid is four parity banks read in
// parallel. Reset clears the pipeline valids and loads the register defaults;
// grid contents stay undefined until written and get no clearing pass.
`default_nettype none

module bilinear_heightmap_sampler
  import bhs_pkg::*;
#(
  parameter int GRID_DIM    = 256,
  parameter int HEIGHT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  bhs_in_if.sink               din,
  bhs_out_if.source            dout
);

  localparam int CW = $clog2(GRID_DIM);
  localparam int BW = HEIGHT_BITS + 2 * FRAC_W + 1;

  logic signed [POS_W-1:0] origin_x, origin_z;
  logic [CPU_W-1:0]        cells_per_unit;
  logic [GAIN_W-1:0]       height_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= ORIGIN_RST;
      origin_z       <= ORIGIN_RST;
      cells_per_unit <= CPU_RST;
      height_gain    <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X:       origin_x       <= $signed(cfg_wdata[POS_W-1:0]);
        CFG_ORIGIN_Z:       origin_z       <= $signed(cfg_wdata[POS_W-1:0]);
        CFG_CELLS_PER_UNIT: cells_per_unit <= cfg_wdata[CPU_W-1:0];
        CFG_HEIGHT_GAIN:    height_gain    <= cfg_wdata[GAIN_W-1:0];
      endcase
    end
  end

  logic                          m_valid, m_ready;
  ctl_t                          m_ctl;
  logic [CW-1:0]                 m_lx, m_lz, m_wx, m_wz;
  logic [WT_W-1:0]               m_fx, m_fz;
  logic signed [HEIGHT_BITS-1:0] m_wh;

  logic                          g_valid, g_ready;
  ctl_t                          g_ctl;
  logic [WT_W-1:0]               g_fx, g_fz;
  logic signed [HEIGHT_BITS-1:0] g_c00, g_c10, g_c01, g_c11;

  logic                          b_valid, b_ready;
  ctl_t                          b_ctl;
  logic signed [BW-1:0]          b_blend;

  bhs_map #(
    .GRID_DIM    (GRID_DIM),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_map (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (din.valid),
    .in_ready       (din.ready),
    .op             (din.op),
    .pos_x          (din.pos_x),
    .pos_z          (din.pos_z),
    .cell_x         (din.cell_x),
    .cell_z         (din.cell_z),
    .cell_height    (din.cell_height),
    .origin_x       (origin_x),
    .origin_z       (origin_z),
    .cells_per_unit (cells_per_unit),
    .out_valid      (m_valid),
    .out_ready      (m_ready),
    .ctl            (m_ctl),
    .lx             (m_lx),
    .lz             (m_lz),
    .fx             (m_fx),
    .fz             (m_fz),
    .wr_x           (m_wx),
    .wr_z           (m_wz),
    .wr_h           (m_wh)
  );

  bhs_grid #(
    .GRID_DIM    (GRID_DIM),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_grid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ready  (m_ready),
    .ctl_in    (m_ctl),
    .lx        (m_lx),
    .lz        (m_lz),
    .fx_in     (m_fx),
    .fz_in     (m_fz),
    .wr_x      (m_wx),
    .wr_z      (m_wz),
    .wr_h      (m_wh),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .ctl       (g_ctl),
    .fx        (g_fx),
    .fz        (g_fz),
    .c00       (g_c00),
    .c10       (g_c10),
    .c01       (g_c01),
    .c11       (g_c11)
  );

  bhs_blend #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .ctl_in    (g_ctl),
    .fx        (g_fx),
    .fz        (g_fz),
    .c00       (g_c00),
    .c10       (g_c10),
    .c01       (g_c01),
    .c11       (g_c11),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .ctl       (b_ctl),
    .blend     (b_blend)
  );

  bhs_scale #(
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (b_valid),
    .in_ready     (b_ready),
    .ctl_in       (b_ctl),
    .blend        (b_blend),
    .gain         (height_gain),
    .out_valid    (dout.valid),
    .out_ready    (dout.ready),
    .height_out   (dout.height_out),
    .out_of_range (dout.out_of_range)
  );

endmodule

`default_nettype wire

// ----- sv/bhs_chk.sv -----
// Port-level checker for the sampler, bound to the top level.
// Depends on bhs_pkg and bilinear_heightmap_sampler.
`default_nettype none

module bhs_chk
  import bhs_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] height_out,
  input logic                    out_of_range
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (in_acc && !out_acc) begin
      inflight <= inflight + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      inflight <= inflight - CNT_W'(1);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(height_out) && $stable(out_of_range))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with empty output stage");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CNT_W'(PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != '0)
    else $error("result word without a request");

endmodule

bind bilinear_heightmap_sampler bhs_chk u_bhs_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (din.valid),
  .in_ready     (din.ready),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .height_out   (dout.height_out),
  .out_of_range (dout.out_of_range)
);

`default_nettype wire
